>>> design/rdcs_pkg.sv
// Shared types and constants for the rod distance constraint solver.
`timescale 1ns / 1ps

package rdcs_pkg;

  // Datapath widths in bits, and the fixed-point unit shift
  localparam int unsigned POS_W       = 32;
  localparam int unsigned DIFF_W      = 33;
  localparam int unsigned MAG_W       = 33;
  localparam int unsigned MASS_W      = 32;
  localparam int unsigned MSUM_W      = 33;
  localparam int unsigned ROD_W       = 31;
  localparam int unsigned SUM_W       = 66;
  localparam int unsigned ROOT_W      = 33;
  localparam int unsigned REM_W       = 34;
  localparam int unsigned UNIT_SHIFT  = 30;
  localparam int unsigned NUM_W       = 63;
  localparam int unsigned DEN_W       = 33;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned DELTA_W     = 33;
  localparam int unsigned FPROD_W     = 62;
  localparam int unsigned MPROD_W     = 64;
  localparam int unsigned MOVE_W      = 34;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Pipeline shape
  localparam int unsigned SQRT_ITERS   = 33;
  localparam int unsigned SQRT_STAGES  = SQRT_ITERS + 1;
  localparam int unsigned DIV_LANES    = 4;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned BACK_STAGES  = 5;
  localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STAGES + 1 + QUO_W + BACK_STAGES;

  // Divider lanes
  localparam int unsigned LANE_UX = 0;
  localparam int unsigned LANE_UY = 1;
  localparam int unsigned LANE_R1 = 2;
  localparam int unsigned LANE_R2 = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROD_LENGTH = 3'd0,
    CFG_ANCHOR_A_X = 3'd1,
    CFG_ANCHOR_A_Y = 3'd2,
    CFG_ANCHOR_B_X = 3'd3,
    CFG_ANCHOR_B_Y = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_SOLVED    = 2'd0,
    OUT_SKIPPED   = 2'd1,
    OUT_ZERO_DIST = 2'd2,
    OUT_ZERO_MASS = 2'd3
  } outcome_e;

  // Item context carried alongside the square root
  typedef struct packed {
    logic                     has1;
    logic                     has2;
    logic signed [POS_W-1:0]  x1;
    logic signed [POS_W-1:0]  y1;
    logic signed [POS_W-1:0]  x2;
    logic signed [POS_W-1:0]  y2;
    logic [MAG_W-1:0]         adx;
    logic [MAG_W-1:0]         ady;
    logic                     dx_neg;
    logic                     dx_pos;
    logic                     dy_neg;
    logic                     dy_pos;
    logic                     zero_dist;
    logic [MASS_W-1:0]        m1;
    logic [MASS_W-1:0]        m2;
    logic [MSUM_W-1:0]        msum;
  } sq_ctx_t;

  // Item context carried alongside the dividers and the move stages
  typedef struct packed {
    logic                     has1;
    logic                     has2;
    logic signed [POS_W-1:0]  x1;
    logic signed [POS_W-1:0]  y1;
    logic signed [POS_W-1:0]  x2;
    logic signed [POS_W-1:0]  y2;
    logic                     neg_x1;
    logic                     neg_y1;
    logic                     move_en;
    logic                     violated;
    outcome_e                 outcome;
    logic [DELTA_W-1:0]       delta;
  } dv_ctx_t;

endpackage

>>> design/rdcs_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
`timescale 1ns / 1ps

module rdcs_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [rdcs_pkg::SUM_W-1:0]    radicand_i,
  input  rdcs_pkg::sq_ctx_t             ctx_i,
  output logic                          valid_o,
  output logic [rdcs_pkg::ROOT_W-1:0]   root_o,
  output rdcs_pkg::sq_ctx_t             ctx_o
);
  import rdcs_pkg::*;

  logic              vld_q  [SQRT_ITERS];
  logic [ROOT_W-1:0] root_q [SQRT_ITERS];
  logic [REM_W-1:0]  rem_q  [SQRT_ITERS];
  logic [SUM_W-1:0]  rad_q  [SQRT_ITERS];
  sq_ctx_t           ctx_q  [SQRT_ITERS];

  genvar k;
  for (k = 0; k < SQRT_ITERS; k++) begin : g_iter
    logic              vld_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [SUM_W-1:0]  rad_in;
    sq_ctx_t           ctx_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [ROOT_W-1:0] root_d;
    logic [REM_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = radicand_i;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign ctx_in  = ctx_q[k-1];
    end

    // one restoring step on the top bit pair
    always_comb begin
      rem_sh = {rem_in, rad_in[SUM_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[REM_W-1:0];
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k] <= root_d;
      rem_q[k]  <= rem_d;
      rad_q[k]  <= rad_in << 2;
      ctx_q[k]  <= ctx_in;
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  logic              vld_r_q;
  logic [ROOT_W-1:0] root_r_q;
  sq_ctx_t           ctx_r_q;
  logic              round_up;

  assign round_up = rem_q[SQRT_ITERS-1] > {1'b0, root_q[SQRT_ITERS-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else begin
      vld_r_q <= vld_q[SQRT_ITERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    root_r_q <= root_q[SQRT_ITERS-1] + ROOT_W'(round_up);
    ctx_r_q  <= ctx_q[SQRT_ITERS-1];
  end

  assign valid_o = vld_r_q;
  assign root_o  = root_r_q;
  assign ctx_o   = ctx_r_q;

endmodule

>>> design/rdcs_div.sv
// Four-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module rdcs_div (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic [rdcs_pkg::DIV_LANES-1:0][rdcs_pkg::NUM_W-1:0] num_i,
  input  logic [rdcs_pkg::DIV_LANES-1:0][rdcs_pkg::DEN_W-1:0] den_i,
  input  rdcs_pkg::dv_ctx_t                                   ctx_i,
  output logic                                                valid_o,
  output logic [rdcs_pkg::DIV_LANES-1:0][rdcs_pkg::QUO_W-1:0] quo_o,
  output rdcs_pkg::dv_ctx_t                                   ctx_o
);
  import rdcs_pkg::*;

  // quotients stay below 2^31, so the upper numerator bits start as remainder
  logic                                vld_q [QUO_W];
  logic [DIV_LANES-1:0][DEN_W-1:0]     rem_q [QUO_W];
  logic [DIV_LANES-1:0][DEN_W-1:0]     den_q [QUO_W];
  logic [DIV_LANES-1:0][QUO_W-1:0]     low_q [QUO_W];
  logic [DIV_LANES-1:0][QUO_W-1:0]     quo_q [QUO_W];
  dv_ctx_t                             ctx_q [QUO_W];

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_step
    logic                            vld_in;
    logic [DIV_LANES-1:0][DEN_W-1:0] rem_in;
    logic [DIV_LANES-1:0][DEN_W-1:0] den_in;
    logic [DIV_LANES-1:0][QUO_W-1:0] low_in;
    logic [DIV_LANES-1:0][QUO_W-1:0] quo_in;
    dv_ctx_t                         ctx_in;
    logic [DIV_LANES-1:0][DEN_W:0]   sh;
    logic [DIV_LANES-1:0][DEN_W-1:0] rem_d;
    logic [DIV_LANES-1:0][QUO_W-1:0] quo_d;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        assign rem_in[l] = DEN_W'(num_i[l][NUM_W-1:QUO_W]);
        assign low_in[l] = num_i[l][QUO_W-1:0];
      end
      assign vld_in = valid_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    // trial subtract per lane
    always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
        sh[l] = {rem_in[l], low_in[l][QUO_W-1]};
        if (sh[l] >= {1'b0, den_in[l]}) begin
          rem_d[l] = DEN_W'(sh[l] - {1'b0, den_in[l]});
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = sh[l][DEN_W-1:0];
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= quo_d;
      ctx_q[k] <= ctx_in;
      for (int l = 0; l < DIV_LANES; l++) begin
        low_q[k][l] <= low_in[l] << 1;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign ctx_o   = ctx_q[QUO_W-1];

endmodule

>>> design/rod_distance_constraint_solve_top.sv
// Top level of the rod distance constraint solver: config, front end, moves, output.
`timescale 1ns / 1ps
// Each accepted item gives one done_o strobe; results leave in the order the items were accepted.
// Throughput: one item per cycle; busy_o never rises, the receiver cannot stall.
// Depth is set by the 34-stage square root and the 31-stage four-lane divider.
// Reset (rst_ni low, asynchronous) clears all config registers to 0 and empties the pipeline.

module rod_distance_constraint_solve_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        first_present_i,
  input  logic        second_present_i,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] first_mass_i,
  input  logic [31:0] second_mass_i,
  output logic        done_o,
  output logic [31:0] new_first_x_o,
  output logic [31:0] new_first_y_o,
  output logic [31:0] new_second_x_o,
  output logic [31:0] new_second_y_o,
  output logic        violated_o,
  output logic [1:0]  outcome_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import rdcs_pkg::*;

  localparam logic [FPROD_W-1:0] F_HALF = FPROD_W'(1) << (UNIT_SHIFT - 1);
  localparam logic [MPROD_W-1:0] M_HALF = MPROD_W'(1) << (UNIT_SHIFT - 1);

  function automatic logic [POS_W-1:0] sat_move(logic signed [POS_W-1:0] pos,
                                                logic [MOVE_W-1:0] mag, logic neg);
    logic signed [MOVE_W+1:0] m;
    logic signed [MOVE_W+1:0] s;
    m = $signed({2'b00, mag});
    s = neg ? (36'(pos) - m) : (36'(pos) + m);
    if (s > 36'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -36'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[POS_W-1:0];
  endfunction

  // no back-pressure anywhere
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  logic [ROD_W-1:0]        rod_length_q;
  logic signed [POS_W-1:0] anchor_a_x_q, anchor_a_y_q, anchor_b_x_q, anchor_b_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_length_q <= '0;
      anchor_a_x_q <= '0;
      anchor_a_y_q <= '0;
      anchor_b_x_q <= '0;
      anchor_b_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROD_LENGTH: rod_length_q <= cfg_data_i[ROD_W-1:0];
        CFG_ANCHOR_A_X: anchor_a_x_q <= cfg_data_i;
        CFG_ANCHOR_A_Y: anchor_a_y_q <= cfg_data_i;
        CFG_ANCHOR_B_X: anchor_b_x_q <= cfg_data_i;
        CFG_ANCHOR_B_Y: anchor_b_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage A: pick bodies or anchors, take differences
  logic                     acc;
  logic signed [POS_W-1:0]  x1_sel, y1_sel, x2_sel, y2_sel;
  logic                     a_vld_q;
  logic                     a_has1_q, a_has2_q;
  logic signed [POS_W-1:0]  a_x1_q, a_y1_q, a_x2_q, a_y2_q;
  logic [MASS_W-1:0]        a_m1_q, a_m2_q;
  logic signed [DIFF_W-1:0] a_dx_q, a_dy_q;

  assign acc    = start_i && !busy_o;
  assign x1_sel = first_present_i  ? first_x_i  : anchor_a_x_q;
  assign y1_sel = first_present_i  ? first_y_i  : anchor_a_y_q;
  assign x2_sel = second_present_i ? second_x_i : anchor_b_x_q;
  assign y2_sel = second_present_i ? second_y_i : anchor_b_y_q;

  always_ff @(posedge clk_i) begin
    a_has1_q <= first_present_i;
    a_has2_q <= second_present_i;
    a_x1_q   <= x1_sel;
    a_y1_q   <= y1_sel;
    a_x2_q   <= x2_sel;
    a_y2_q   <= y2_sel;
    a_m1_q   <= first_present_i  ? first_mass_i  : '0;
    a_m2_q   <= second_present_i ? second_mass_i : '0;
    a_dx_q   <= DIFF_W'(x1_sel) - DIFF_W'(x2_sel);
    a_dy_q   <= DIFF_W'(y1_sel) - DIFF_W'(y2_sel);
  end

  // stage B: magnitudes, signs, mass sum
  logic    b_vld_q;
  sq_ctx_t b_ctx_q;

  always_ff @(posedge clk_i) begin
    b_ctx_q.has1      <= a_has1_q;
    b_ctx_q.has2      <= a_has2_q;
    b_ctx_q.x1        <= a_x1_q;
    b_ctx_q.y1        <= a_y1_q;
    b_ctx_q.x2        <= a_x2_q;
    b_ctx_q.y2        <= a_y2_q;
    b_ctx_q.adx       <= a_dx_q[DIFF_W-1] ? MAG_W'(-a_dx_q) : MAG_W'(a_dx_q);
    b_ctx_q.ady       <= a_dy_q[DIFF_W-1] ? MAG_W'(-a_dy_q) : MAG_W'(a_dy_q);
    b_ctx_q.dx_neg    <= a_dx_q[DIFF_W-1];
    b_ctx_q.dx_pos    <= !a_dx_q[DIFF_W-1] && (a_dx_q != '0);
    b_ctx_q.dy_neg    <= a_dy_q[DIFF_W-1];
    b_ctx_q.dy_pos    <= !a_dy_q[DIFF_W-1] && (a_dy_q != '0);
    b_ctx_q.zero_dist <= (a_dx_q == '0) && (a_dy_q == '0);
    b_ctx_q.m1        <= a_m1_q;
    b_ctx_q.m2        <= a_m2_q;
    b_ctx_q.msum      <= MSUM_W'(a_m1_q) + MSUM_W'(a_m2_q);
  end

  // stage C: squares
  logic             c_vld_q;
  sq_ctx_t          c_ctx_q;
  logic [SUM_W-1:0] c_sqx_q, c_sqy_q;

  always_ff @(posedge clk_i) begin
    c_ctx_q <= b_ctx_q;
    c_sqx_q <= SUM_W'(b_ctx_q.adx * b_ctx_q.adx);
    c_sqy_q <= SUM_W'(b_ctx_q.ady * b_ctx_q.ady);
  end

  // stage D: radicand
  logic             d_vld_q;
  sq_ctx_t          d_ctx_q;
  logic [SUM_W-1:0] d_rad_q;

  always_ff @(posedge clk_i) begin
    d_ctx_q <= c_ctx_q;
    d_rad_q <= c_sqx_q + c_sqy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= acc;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  // distance
  logic              s_vld;
  logic [ROOT_W-1:0] s_dist;
  sq_ctx_t           s_ctx;

  rdcs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d_vld_q),
    .radicand_i (d_rad_q),
    .ctx_i      (d_ctx_q),
    .valid_o    (s_vld),
    .root_o     (s_dist),
    .ctx_o      (s_ctx)
  );

  // stage E: classify, length error, divider operands
  logic [ROOT_W-1:0]               rod_ext;
  logic                            e_comp, e_viol_raw, e_skip;
  outcome_e                        e_outcome;
  logic                            e_vld_q;
  dv_ctx_t                         e_ctx_q;
  logic [DIV_LANES-1:0][NUM_W-1:0] e_num_q;
  logic [DIV_LANES-1:0][DEN_W-1:0] e_den_q;

  assign rod_ext    = ROOT_W'(rod_length_q);
  assign e_comp     = s_dist < rod_ext;
  assign e_viol_raw = s_dist != rod_ext;
  assign e_skip     = !s_ctx.has1 && !s_ctx.has2;

  always_comb begin
    priority if (e_skip) begin
      e_outcome = OUT_SKIPPED;
    end else if (s_ctx.zero_dist) begin
      e_outcome = OUT_ZERO_DIST;
    end else if (s_ctx.msum == '0) begin
      e_outcome = OUT_ZERO_MASS;
    end else begin
      e_outcome = OUT_SOLVED;
    end
  end

  always_ff @(posedge clk_i) begin
    e_ctx_q.has1     <= s_ctx.has1;
    e_ctx_q.has2     <= s_ctx.has2;
    e_ctx_q.x1       <= s_ctx.x1;
    e_ctx_q.y1       <= s_ctx.y1;
    e_ctx_q.x2       <= s_ctx.x2;
    e_ctx_q.y2       <= s_ctx.y2;
    e_ctx_q.neg_x1   <= e_comp ? s_ctx.dx_neg : s_ctx.dx_pos;
    e_ctx_q.neg_y1   <= e_comp ? s_ctx.dy_neg : s_ctx.dy_pos;
    e_ctx_q.move_en  <= (e_outcome == OUT_SOLVED) && e_viol_raw;
    e_ctx_q.violated <= !e_skip && e_viol_raw;
    e_ctx_q.outcome  <= e_outcome;
    e_ctx_q.delta    <= e_comp ? DELTA_W'(rod_ext - s_dist) : DELTA_W'(s_dist - rod_ext);
    // rounded quotients: (a * 2^30 + d/2) / d; a zero divisor is replaced, result unused
    e_num_q[LANE_UX] <= (NUM_W'(s_ctx.adx) << UNIT_SHIFT) + NUM_W'(s_dist >> 1);
    e_num_q[LANE_UY] <= (NUM_W'(s_ctx.ady) << UNIT_SHIFT) + NUM_W'(s_dist >> 1);
    e_num_q[LANE_R1] <= (NUM_W'(s_ctx.m1) << UNIT_SHIFT) + NUM_W'(s_ctx.msum >> 1);
    e_num_q[LANE_R2] <= (NUM_W'(s_ctx.m2) << UNIT_SHIFT) + NUM_W'(s_ctx.msum >> 1);
    e_den_q[LANE_UX] <= s_ctx.zero_dist ? DEN_W'(1) : DEN_W'(s_dist);
    e_den_q[LANE_UY] <= s_ctx.zero_dist ? DEN_W'(1) : DEN_W'(s_dist);
    e_den_q[LANE_R1] <= (s_ctx.msum == '0) ? DEN_W'(1) : DEN_W'(s_ctx.msum);
    e_den_q[LANE_R2] <= (s_ctx.msum == '0) ? DEN_W'(1) : DEN_W'(s_ctx.msum);
  end

  // unit direction and mass ratios
  logic                            q_vld;
  logic [DIV_LANES-1:0][QUO_W-1:0] q_quo;
  dv_ctx_t                         q_ctx;

  rdcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .num_i   (e_num_q),
    .den_i   (e_den_q),
    .ctx_i   (e_ctx_q),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .ctx_o   (q_ctx)
  );

  // stages F to I: ratio times direction, then times length error
  // order of the four moves: first x, first y, second x, second y
  logic                              f_vld_q, g_vld_q, h_vld_q, i_vld_q, j_vld_q;
  dv_ctx_t                           f_ctx_q, g_ctx_q, h_ctx_q, i_ctx_q;
  logic [DIV_LANES-1:0][FPROD_W-1:0] f_prod_q;
  logic [DIV_LANES-1:0][QUO_W-1:0]   g_frac_q;
  logic [DIV_LANES-1:0][MPROD_W-1:0] h_prod_q;
  logic [DIV_LANES-1:0][MOVE_W-1:0]  i_move_q;
  logic [DIV_LANES-1:0][FPROD_W-1:0] g_rnd;
  logic [DIV_LANES-1:0][MPROD_W-1:0] i_rnd;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      g_rnd[l] = f_prod_q[l] + F_HALF;
      i_rnd[l] = h_prod_q[l] + M_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    f_ctx_q     <= q_ctx;
    f_prod_q[0] <= FPROD_W'(q_quo[LANE_R1] * q_quo[LANE_UX]);
    f_prod_q[1] <= FPROD_W'(q_quo[LANE_R1] * q_quo[LANE_UY]);
    f_prod_q[2] <= FPROD_W'(q_quo[LANE_R2] * q_quo[LANE_UX]);
    f_prod_q[3] <= FPROD_W'(q_quo[LANE_R2] * q_quo[LANE_UY]);
    g_ctx_q     <= f_ctx_q;
    h_ctx_q     <= g_ctx_q;
    i_ctx_q     <= h_ctx_q;
    for (int l = 0; l < DIV_LANES; l++) begin
      g_frac_q[l] <= g_rnd[l][UNIT_SHIFT +: QUO_W];
      h_prod_q[l] <= MPROD_W'(g_frac_q[l] * g_ctx_q.delta);
      i_move_q[l] <= i_rnd[l][UNIT_SHIFT +: MOVE_W];
    end
  end

  // stage J: saturating position update, output registers
  logic              mv1, mv2;
  logic [POS_W-1:0]  j_x1_q, j_y1_q, j_x2_q, j_y2_q;
  logic              j_viol_q;
  outcome_e          j_outcome_q;

  assign mv1 = i_ctx_q.move_en && i_ctx_q.has1;
  assign mv2 = i_ctx_q.move_en && i_ctx_q.has2;

  always_ff @(posedge clk_i) begin
    j_x1_q      <= mv1 ? sat_move(i_ctx_q.x1, i_move_q[0], i_ctx_q.neg_x1) : i_ctx_q.x1;
    j_y1_q      <= mv1 ? sat_move(i_ctx_q.y1, i_move_q[1], i_ctx_q.neg_y1) : i_ctx_q.y1;
    j_x2_q      <= mv2 ? sat_move(i_ctx_q.x2, i_move_q[2], !i_ctx_q.neg_x1) : i_ctx_q.x2;
    j_y2_q      <= mv2 ? sat_move(i_ctx_q.y2, i_move_q[3], !i_ctx_q.neg_y1) : i_ctx_q.y2;
    j_viol_q    <= i_ctx_q.violated;
    j_outcome_q <= i_ctx_q.outcome;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
    end else begin
      e_vld_q <= s_vld;
      f_vld_q <= q_vld;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
      j_vld_q <= i_vld_q;
    end
  end

  assign done_o         = j_vld_q;
  assign new_first_x_o  = j_x1_q;
  assign new_first_y_o  = j_y1_q;
  assign new_second_x_o = j_x2_q;
  assign new_second_y_o = j_y2_q;
  assign violated_o     = j_viol_q;
  assign outcome_o      = j_outcome_q;

  // every accepted item comes out as a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LATENCY done_o)
    else $error("item lost in pipeline");

  // no result without a matching accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LATENCY))
    else $error("result without matching item");

  // a skipped joint never reports a violation
  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (outcome_o == OUT_SKIPPED)) |-> !violated_o)
    else $error("skipped item flagged as violated");

endmodule

>>> tb/rdcs_checker.sv
// Checker for the rod distance constraint solver: watches the channels, predicts results and compares.
`timescale 1ns / 1ps

module rdcs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        first_present_i,
  input  logic        second_present_i,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] first_mass_i,
  input  logic [31:0] second_mass_i,
  input  logic        done_i,
  input  logic [31:0] new_first_x_i,
  input  logic [31:0] new_first_y_i,
  input  logic [31:0] new_second_x_i,
  input  logic [31:0] new_second_y_i,
  input  logic        violated_i,
  input  logic [1:0]  outcome_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import rdcs_pkg::*;

  typedef struct packed {
    logic [31:0] nx1;
    logic [31:0] ny1;
    logic [31:0] nx2;
    logic [31:0] ny2;
    logic        violated;
    outcome_e    outcome;
  } joint_res_t;

  localparam longint unsigned HALF = 64'd1 << (UNIT_SHIFT - 1);

  // Local copy of the registers
  logic [30:0] rod_len_q;
  logic [31:0] anc_ax_q, anc_ay_q, anc_bx_q, anc_by_q;

  joint_res_t  joint_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = joint_q.size();

  // Rounded integer square root of a sum of two squares
  function automatic longint unsigned root_round(logic [65:0] v);
    longint unsigned root, rem, trial;
    root = 0;
    rem  = 0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | longint'(v[2*i +: 2]);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root++;
    return root;
  endfunction

  function automatic longint unsigned move_size(longint unsigned ratio, longint unsigned unit,
                                                longint unsigned delta);
    longint unsigned f;
    f = (ratio * unit + HALF) >> UNIT_SHIFT;
    return (f * delta + HALF) >> UNIT_SHIFT;
  endfunction

  function automatic logic [31:0] sat_move(longint pos, longint unsigned mag, logic neg);
    longint s;
    s = neg ? pos - longint'(mag) : pos + longint'(mag);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic joint_res_t solve_joint(logic h1, logic h2, logic [31:0] px1,
                                             logic [31:0] py1, logic [31:0] px2,
                                             logic [31:0] py2, logic [31:0] pm1,
                                             logic [31:0] pm2);
    joint_res_t      r;
    longint          x1, y1, x2, y2, dx, dy;
    longint unsigned adx, ady, m1, m2, msum, dist_len, delta, ux, uy, rat;
    logic [65:0]     sq;
    logic            comp, nx, ny;
    x1 = h1 ? longint'($signed(px1)) : longint'($signed(anc_ax_q));
    y1 = h1 ? longint'($signed(py1)) : longint'($signed(anc_ay_q));
    x2 = h2 ? longint'($signed(px2)) : longint'($signed(anc_bx_q));
    y2 = h2 ? longint'($signed(py2)) : longint'($signed(anc_by_q));
    m1 = h1 ? longint'(pm1) : 0;
    m2 = h2 ? longint'(pm2) : 0;
    r.nx1 = x1[31:0];
    r.ny1 = y1[31:0];
    r.nx2 = x2[31:0];
    r.ny2 = y2[31:0];
    r.violated = 1'b0;
    r.outcome = OUT_SOLVED;
    if (!h1 && !h2) begin
      r.outcome = OUT_SKIPPED;
      return r;
    end
    dx = x1 - x2;
    dy = y1 - y2;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sq = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
    dist_len = root_round(sq);
    msum = m1 + m2;
    r.violated = (dist_len != longint'(rod_len_q));
    if (dx == 0 && dy == 0) begin
      r.outcome = OUT_ZERO_DIST;
    end else if (msum == 0) begin
      r.outcome = OUT_ZERO_MASS;
    end else if (r.violated) begin
      comp  = dist_len < longint'(rod_len_q);
      delta = comp ? longint'(rod_len_q) - dist_len : dist_len - longint'(rod_len_q);
      ux = ((adx << UNIT_SHIFT) + dist_len / 2) / dist_len;
      uy = ((ady << UNIT_SHIFT) + dist_len / 2) / dist_len;
      // first end moves along +d on compression, -d on extension
      nx = comp ? (dx < 0) : (dx > 0);
      ny = comp ? (dy < 0) : (dy > 0);
      if (h1) begin
        rat = ((m1 << UNIT_SHIFT) + msum / 2) / msum;
        r.nx1 = sat_move(x1, move_size(rat, ux, delta), nx);
        r.ny1 = sat_move(y1, move_size(rat, uy, delta), ny);
      end
      if (h2) begin
        rat = ((m2 << UNIT_SHIFT) + msum / 2) / msum;
        r.nx2 = sat_move(x2, move_size(rat, ux, delta), !nx);
        r.ny2 = sat_move(y2, move_size(rat, uy, delta), !ny);
      end
    end
    return r;
  endfunction

  // Register writes, accepted items and results, all sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    joint_res_t e;
    if (!rst_ni) begin
      rod_len_q <= '0;
      anc_ax_q  <= '0;
      anc_ay_q  <= '0;
      anc_bx_q  <= '0;
      anc_by_q  <= '0;
      joint_q.delete();
      fails = 0;
    end else begin
      if (start_i && !busy_i) begin
        joint_q.push_back(solve_joint(first_present_i, second_present_i, first_x_i, first_y_i,
                                      second_x_i, second_y_i, first_mass_i, second_mass_i));
      end
      if (done_i) begin
        if (joint_q.size() == 0) begin
          $error("result with no item waiting");
          fails++;
        end else begin
          e = joint_q.pop_front();
          if (new_first_x_i !== e.nx1) begin
            $error("new_first_x exp %h got %h", e.nx1, new_first_x_i); fails++;
          end
          if (new_first_y_i !== e.ny1) begin
            $error("new_first_y exp %h got %h", e.ny1, new_first_y_i); fails++;
          end
          if (new_second_x_i !== e.nx2) begin
            $error("new_second_x exp %h got %h", e.nx2, new_second_x_i); fails++;
          end
          if (new_second_y_i !== e.ny2) begin
            $error("new_second_y exp %h got %h", e.ny2, new_second_y_i); fails++;
          end
          if (violated_i !== e.violated) begin
            $error("violated exp %b got %b", e.violated, violated_i); fails++;
          end
          if (outcome_i !== e.outcome) begin
            $error("outcome exp %0d got %0d", e.outcome, outcome_i); fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROD_LENGTH: rod_len_q <= cfg_data_i[30:0];
          CFG_ANCHOR_A_X: anc_ax_q  <= cfg_data_i;
          CFG_ANCHOR_A_Y: anc_ay_q  <= cfg_data_i;
          CFG_ANCHOR_B_X: anc_bx_q  <= cfg_data_i;
          CFG_ANCHOR_B_Y: anc_by_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the rod distance constraint solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rdcs_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES      = 11;
  localparam int unsigned PHASE_ITEMS = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        first_present_i = 1'b0, second_present_i = 1'b0;
  logic [31:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic [31:0] first_mass_i = '0, second_mass_i = '0;
  logic        done_o;
  logic [31:0] new_first_x_o, new_first_y_o, new_second_x_o, new_second_y_o;
  logic        violated_o;
  logic [1:0]  outcome_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int unsigned fail_count, pending;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  rod_distance_constraint_solve_top dut (.*);

  rdcs_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .first_present_i, .second_present_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .first_mass_i, .second_mass_i,
    .done_i(done_o), .new_first_x_i(new_first_x_o), .new_first_y_i(new_first_y_o),
    .new_second_x_i(new_second_x_o), .new_second_y_i(new_second_y_o),
    .violated_i(violated_o), .outcome_i(outcome_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: cycles with no item, result or register write accepted
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] len, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] bx, logic [31:0] by);
    write_reg(CFG_ROD_LENGTH, len);
    write_reg(CFG_ANCHOR_A_X, ax);
    write_reg(CFG_ANCHOR_A_Y, ay);
    write_reg(CFG_ANCHOR_B_X, bx);
    write_reg(CFG_ANCHOR_B_Y, by);
  endtask

  // Hold off until every result is back, then let the pipe drain
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic send_joint(logic h1, logic h2, logic [31:0] x1, logic [31:0] y1,
                            logic [31:0] x2, logic [31:0] y2, logic [31:0] m1,
                            logic [31:0] m2);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    first_present_i <= h1;
    second_present_i <= h2;
    first_x_i <= x1;
    first_y_i <= y1;
    second_x_i <= x2;
    second_y_i <= y2;
    first_mass_i <= m1;
    second_mass_i <= m2;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // Random joint: mostly nearby ends with random content, some full-range noise
  task automatic send_random_joint();
    logic [31:0] bx, by, x1, y1, x2, y2;
    int unsigned span;
    bx = $urandom;
    by = $urandom;
    span = (32'd1 << $urandom_range(0, 22));
    if ($urandom_range(0, 3) == 0) begin
      x1 = $urandom; y1 = $urandom; x2 = $urandom; y2 = $urandom;
    end else begin
      x1 = bx + $urandom_range(0, span); y1 = by + $urandom_range(0, span);
      x2 = bx - $urandom_range(0, span); y2 = by - $urandom_range(0, span);
      if ($urandom_range(0, 15) == 0) begin
        x2 = x1; y2 = y1;
      end
    end
    send_joint($urandom_range(0, 7) != 0 ? 1'b1 : 1'($urandom_range(0, 1)),
               $urandom_range(0, 7) != 0 ? 1'b1 : 1'($urandom_range(0, 1)),
               x1, y1, x2, y2, pick_mass(), pick_mass());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults after reset
    send_joint(1'b0, 1'b0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1);
    send_joint(1'b1, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
               32'h0001_0000, 32'h0001_0000);
    send_joint(1'b1, 1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_joint(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_joint(1'b1, 1'b0, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h5);
    send_joint(1'b0, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0001_0000);
    drain();

    // Directed: length equal to distance, compression, one end anchored, skipped, zero distance
    write_all(32'd5, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_joint(1'b1, 1'b1, 32'd3, 32'd4, 32'd0, 32'd0, 32'd1, 32'd1);
    send_joint(1'b1, 1'b1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd3);
    send_joint(1'b0, 1'b1, 32'd0, 32'd0, 32'd2, 32'hFFFF_FFFE, 32'd7, 32'd9);
    send_joint(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_joint(1'b1, 1'b1, 32'd5, 32'd5, 32'd5, 32'd5, 32'd0, 32'd0);
    drain();

    // Directed: longest rod, saturating moves, zero mass
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_joint(1'b1, 1'b1, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF8, 32'h7FFF_FFF8,
               32'hFFFF_FFFF, 32'h1);
    send_joint(1'b1, 1'b1, 32'h8000_0010, 32'h0, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF);
    send_joint(1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_joint(1'b0, 1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1);
    send_joint(1'b0, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    drain();

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) write_all(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
      else write_all(pick_len(), $urandom, $urandom, $urandom, $urandom);
      if (p >= PHASES - 2) gaps_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_joint();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
